### sv/jrsi_pkg.sv
// jrsi_pkg: shared types, constants and helpers for the joystick rate servo integrator
// no dependencies; imported by every jrsi module
`default_nettype none

package jrsi_pkg;

  // level scaling
  localparam int SIGNAL_SCALE = 8192;
  localparam int SCALE_W      = 16;

  // axis ranges
  localparam logic [10:0] PAN_MIN   = 11'd1000;
  localparam logic [10:0] PAN_MAX   = 11'd2000;
  localparam logic [10:0] RIGHT_MIN = 11'd850;
  localparam logic [10:0] RIGHT_MAX = 11'd2000;
  localparam logic [10:0] LEFT_MIN  = 11'd1000;
  localparam logic [10:0] LEFT_MAX  = 11'd2000;

  localparam logic [10:0] PAN_RESET   = 11'd1500;
  localparam logic [10:0] RIGHT_RESET = 11'd1425;
  localparam logic [10:0] LEFT_RESET  = 11'd1500;

  // shared multiplier
  localparam int MUL_A_W = 30;
  localparam int MUL_B_W = 31;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // rate delta: rate*speed*dt / 100000, done as (x >> 5) / 3125 by reciprocal
  localparam int RATE_PRE_SHIFT = 5;
  localparam int RATE_POST_DIV  = 3125;
  localparam int RATE_X_W       = 30;
  localparam int S_RATE         = RATE_X_W + $clog2(RATE_POST_DIV);
  localparam longint unsigned R_RATE_L =
    ((64'd1 << S_RATE) + RATE_POST_DIV - 1) / RATE_POST_DIV;
  localparam logic [MUL_B_W-1:0] R_RATE = MUL_B_W'(R_RATE_L);
  localparam int Q_W = 18;

  // level: (pos-min)*SIGNAL_SCALE / span by reciprocal, numerator below 2^27
  localparam int LVL_X_W    = 27;
  localparam int PAN_SPAN   = 1000;
  localparam int RIGHT_SPAN = 1150;
  localparam int LEFT_SPAN  = 1000;
  localparam int S_PAN      = LVL_X_W + $clog2(PAN_SPAN);
  localparam int S_RIGHT    = LVL_X_W + $clog2(RIGHT_SPAN);
  localparam int S_LEFT     = LVL_X_W + $clog2(LEFT_SPAN);
  localparam longint unsigned R_PAN_L   = ((64'd1 << S_PAN) + PAN_SPAN - 1) / PAN_SPAN;
  localparam longint unsigned R_RIGHT_L = ((64'd1 << S_RIGHT) + RIGHT_SPAN - 1) / RIGHT_SPAN;
  localparam longint unsigned R_LEFT_L  = ((64'd1 << S_LEFT) + LEFT_SPAN - 1) / LEFT_SPAN;
  localparam logic [MUL_B_W-1:0] R_PAN   = MUL_B_W'(R_PAN_L);
  localparam logic [MUL_B_W-1:0] R_RIGHT = MUL_B_W'(R_RIGHT_L);
  localparam logic [MUL_B_W-1:0] R_LEFT  = MUL_B_W'(R_LEFT_L);

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 80;

  typedef enum logic [2:0] {
    REG_PAN_SPEED    = 3'd0,
    REG_TILT_SPEED   = 3'd1,
    REG_DEAD_ZONE    = 3'd2,
    REG_RATE_TIMEOUT = 3'd3,
    REG_UPDATE_INTVL = 3'd4,
    REG_MAX_STEP     = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ENTER = 2'd1,
    EV_EXIT  = 2'd2
  } mode_ev_t;

  typedef struct packed {
    logic [10:0] pan_speed;
    logic [10:0] tilt_speed;
    logic [6:0]  dead_zone;
    logic [15:0] rate_timeout_ms;
    logic [15:0] update_interval_ms;
    logic [15:0] max_step_ms;
  } cfg_regs_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_DECIDE,
    OP_MA1,
    OP_MA2,
    OP_MA3,
    OP_MB1,
    OP_MB2,
    OP_MB3,
    OP_UPDATE,
    OP_LP1,
    OP_LP2,
    OP_LR1,
    OP_LR2,
    OP_LL1,
    OP_LL2,
    OP_FINISH,
    OP_PUSH
  } dp_op_t;

  typedef struct packed {
    logic   load;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic integrate;
    logic out_free;
  } dp_sts_t;

  function automatic logic [10:0] clamp_pos(input logic signed [20:0] v,
                                            input logic [10:0] lo,
                                            input logic [10:0] hi);
    logic signed [20:0] lo_s;
    logic signed [20:0] hi_s;
    lo_s = $signed({10'd0, lo});
    hi_s = $signed({10'd0, hi});
    if (v < lo_s) begin
      return lo;
    end else if (v > hi_s) begin
      return hi;
    end else begin
      return v[10:0];
    end
  endfunction

  function automatic logic [7:0] mag8(input logic signed [7:0] v);
    return v[7] ? 8'(~v + 8'd1) : v;
  endfunction

endpackage

`default_nettype wire

### sv/jrsi_cfg.sv
// jrsi_cfg: configuration register file written over the cfg channel
// depends on jrsi_pkg
`default_nettype none

module jrsi_cfg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [15:0]         cfg_data,
  output jrsi_pkg::cfg_regs_t      regs
);
  import jrsi_pkg::*;

  cfg_regs_t regs_r, regs_nxt;

  assign cfg_ready = 1'b1;
  assign regs      = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_PAN_SPEED:    regs_nxt.pan_speed          = cfg_data[10:0];
        REG_TILT_SPEED:   regs_nxt.tilt_speed         = cfg_data[10:0];
        REG_DEAD_ZONE:    regs_nxt.dead_zone          = cfg_data[6:0];
        REG_RATE_TIMEOUT: regs_nxt.rate_timeout_ms    = cfg_data;
        REG_UPDATE_INTVL: regs_nxt.update_interval_ms = cfg_data;
        REG_MAX_STEP:     regs_nxt.max_step_ms        = cfg_data;
        default:          regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.pan_speed          <= 11'd500;
      regs_r.tilt_speed         <= 11'd500;
      regs_r.dead_zone          <= 7'd20;
      regs_r.rate_timeout_ms    <= 16'd500;
      regs_r.update_interval_ms <= 16'd50;
      regs_r.max_step_ms        <= 16'd200;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/jrsi_ctrl.sv
// jrsi_ctrl: sequencer that steps the datapath through decide, multiply and level steps
// depends on jrsi_pkg
`default_nettype none

module jrsi_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output jrsi_pkg::dp_cmd_t      cmd,
  input  wire jrsi_pkg::dp_sts_t sts
);
  import jrsi_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE   = 17'b00000000000000001,
    S_DEC    = 17'b00000000000000010,
    S_MA1    = 17'b00000000000000100,
    S_MA2    = 17'b00000000000001000,
    S_MA3    = 17'b00000000000010000,
    S_MB1    = 17'b00000000000100000,
    S_MB2    = 17'b00000000001000000,
    S_MB3    = 17'b00000000010000000,
    S_UPD    = 17'b00000000100000000,
    S_LP1    = 17'b00000001000000000,
    S_LP2    = 17'b00000010000000000,
    S_LR1    = 17'b00000100000000000,
    S_LR2    = 17'b00001000000000000,
    S_LL1    = 17'b00010000000000000,
    S_LL2    = 17'b00100000000000000,
    S_FIN    = 17'b01000000000000000,
    S_PUSH   = 17'b10000000000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.load  = in_tvalid && (state_r == S_IDLE);
    cmd.op    = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_DEC;
      end
      S_DEC: begin
        cmd.op    = OP_DECIDE;
        state_nxt = sts.integrate ? S_MA1 : S_LP1;
      end
      S_MA1: begin cmd.op = OP_MA1;    state_nxt = S_MA2; end
      S_MA2: begin cmd.op = OP_MA2;    state_nxt = S_MA3; end
      S_MA3: begin cmd.op = OP_MA3;    state_nxt = S_MB1; end
      S_MB1: begin cmd.op = OP_MB1;    state_nxt = S_MB2; end
      S_MB2: begin cmd.op = OP_MB2;    state_nxt = S_MB3; end
      S_MB3: begin cmd.op = OP_MB3;    state_nxt = S_UPD; end
      S_UPD: begin cmd.op = OP_UPDATE; state_nxt = S_LP1; end
      S_LP1: begin cmd.op = OP_LP1;    state_nxt = S_LP2; end
      S_LP2: begin cmd.op = OP_LP2;    state_nxt = S_LR1; end
      S_LR1: begin cmd.op = OP_LR1;    state_nxt = S_LR2; end
      S_LR2: begin cmd.op = OP_LR2;    state_nxt = S_LL1; end
      S_LL1: begin cmd.op = OP_LL1;    state_nxt = S_LL2; end
      S_LL2: begin cmd.op = OP_LL2;    state_nxt = S_FIN; end
      S_FIN: begin cmd.op = OP_FINISH; state_nxt = S_PUSH; end
      S_PUSH: begin
        cmd.op = OP_PUSH;
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/jrsi_dp.sv
// jrsi_dp: item registers, axis state, shared multiplier and output register
// depends on jrsi_pkg; driven by jrsi_ctrl commands
`default_nettype none

module jrsi_dp (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire jrsi_pkg::dp_cmd_t     cmd,
  output jrsi_pkg::dp_sts_t          sts,
  input  wire jrsi_pkg::cfg_regs_t   cfg,
  input  wire logic [jrsi_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic [0:0]            in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [jrsi_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]                 out_tuser
);
  import jrsi_pkg::*;

  // latched item
  logic               action_r, playback_r, shoulder_r;
  logic [31:0]        now_r, recv_r;
  logic signed [7:0]  rx_r, ry_r;

  // block state
  logic               active_r, active_nxt;
  logic [31:0]        last_step_r;
  logic [10:0]        pan_r, right_r, left_r;

  // per-item working registers
  logic [15:0]        dt_r;
  logic [PROD_W-1:0]  prod_r;
  logic [Q_W-1:0]     qa_r;
  logic               neg_a_r, neg_b_r;
  logic [1:0]         ev_r;
  logic               wp_r, wr_r, wl_r;
  logic [13:0]        lvl_p_r, lvl_r_r, lvl_l_r;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [1:0]            out_user_r;

  // decision
  logic [31:0] age_recv, age_step;
  logic        stale, zero_rates, exit_c, enter_c, integ_c;
  logic [15:0] dt_cap;

  assign age_recv   = now_r - recv_r;
  assign age_step   = now_r - last_step_r;
  assign stale      = (recv_r == 32'd0) || (age_recv >= {16'd0, cfg.rate_timeout_ms});
  assign zero_rates = stale || (rx_r == 8'sd0 && ry_r == 8'sd0);
  assign exit_c     = active_r && (action_r || (playback_r && zero_rates));
  assign enter_c    = !action_r && playback_r && !zero_rates && !active_r;
  assign integ_c    = !action_r && playback_r && !zero_rates && active_r &&
                      (age_step >= {16'd0, cfg.update_interval_ms});
  assign dt_cap     = (age_step > {16'd0, cfg.max_step_ms}) ? cfg.max_step_ms : age_step[15:0];

  // rate magnitudes and pan dead zone
  logic [7:0]  mag_x, mag_y;
  logic        pan_moves;
  assign mag_x     = mag8(rx_r);
  assign mag_y     = mag8(ry_r);
  assign pan_moves = !shoulder_r && (mag_x > {1'b0, cfg.dead_zone});

  // shared multiplier
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;
  logic [10:0]        speed_b;

  assign speed_b = shoulder_r ? cfg.tilt_speed : cfg.pan_speed;
  assign prod    = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MA1: begin
        mul_a = MUL_A_W'(mag_y);
        mul_b = MUL_B_W'(cfg.tilt_speed);
      end
      OP_MB1: begin
        mul_a = MUL_A_W'(mag_x);
        mul_b = MUL_B_W'(speed_b);
      end
      OP_MA2, OP_MB2: begin
        mul_a = MUL_A_W'(prod_r[18:0]);
        mul_b = MUL_B_W'(dt_r);
      end
      OP_MA3, OP_MB3: begin
        mul_a = prod_r[RATE_PRE_SHIFT +: RATE_X_W];
        mul_b = R_RATE;
      end
      OP_LP1: begin
        mul_a = MUL_A_W'(11'(pan_r - PAN_MIN));
        mul_b = MUL_B_W'(SCALE_W'(SIGNAL_SCALE));
      end
      OP_LR1: begin
        mul_a = MUL_A_W'(11'(right_r - RIGHT_MIN));
        mul_b = MUL_B_W'(SCALE_W'(SIGNAL_SCALE));
      end
      OP_LL1: begin
        mul_a = MUL_A_W'(11'(left_r - LEFT_MIN));
        mul_b = MUL_B_W'(SCALE_W'(SIGNAL_SCALE));
      end
      OP_LP2: begin
        mul_a = MUL_A_W'(prod_r[LVL_X_W-1:0]);
        mul_b = R_PAN;
      end
      OP_LR2: begin
        mul_a = MUL_A_W'(prod_r[LVL_X_W-1:0]);
        mul_b = R_RIGHT;
      end
      OP_LL2: begin
        mul_a = MUL_A_W'(prod_r[LVL_X_W-1:0]);
        mul_b = R_LEFT;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // signed deltas and new positions
  logic [Q_W-1:0]      qb;
  logic signed [20:0]  da, db, xd, rtot, ltot, pan_sum, right_sum, left_sum;

  assign qb        = prod_r[S_RATE +: Q_W];
  assign da        = neg_a_r ? -$signed({3'd0, qa_r}) : $signed({3'd0, qa_r});
  assign db        = neg_b_r ? -$signed({3'd0, qb}) : $signed({3'd0, qb});
  assign xd        = shoulder_r ? db : 21'sd0;
  assign rtot      = da + xd;
  assign ltot      = xd - da;
  assign pan_sum   = $signed({10'd0, pan_r}) + db;
  assign right_sum = $signed({10'd0, right_r}) + rtot;
  assign left_sum  = $signed({10'd0, left_r}) + ltot;

  // level quotients as they leave the multiplier
  logic [13:0] lvl_from_pan, lvl_from_right, lvl_from_left;
  assign lvl_from_pan   = prod_r[S_PAN +: 14];
  assign lvl_from_right = prod_r[S_RIGHT +: 14];
  assign lvl_from_left  = prod_r[S_LEFT +: 14];

  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    sts.integrate = integ_c;
    sts.out_free  = out_free;
  end

  always_comb begin
    active_nxt = active_r;
    if (cmd.op == OP_DECIDE) begin
      if (exit_c) begin
        active_nxt = 1'b0;
      end else if (enter_c) begin
        active_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      last_step_r <= 32'd0;
      pan_r       <= PAN_RESET;
      right_r     <= RIGHT_RESET;
      left_r      <= LEFT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      if (cmd.op == OP_DECIDE && (enter_c || integ_c)) last_step_r <= now_r;
      if (cmd.op == OP_UPDATE) begin
        if (pan_moves)      pan_r   <= clamp_pos(pan_sum, PAN_MIN, PAN_MAX);
        if (rtot != 21'sd0) right_r <= clamp_pos(right_sum, RIGHT_MIN, RIGHT_MAX);
        if (ltot != 21'sd0) left_r  <= clamp_pos(left_sum, LEFT_MIN, LEFT_MAX);
      end
      if (cmd.op == OP_PUSH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r   <= in_tuser[0];
      playback_r <= in_tdata[0];
      now_r      <= in_tdata[32:1];
      recv_r     <= in_tdata[64:33];
      rx_r       <= $signed(in_tdata[72:65]);
      ry_r       <= $signed(in_tdata[80:73]);
      shoulder_r <= in_tdata[81];
    end
    prod_r <= prod;
    case (cmd.op)
      OP_DECIDE: begin
        dt_r    <= dt_cap;
        neg_a_r <= !ry_r[7] && (ry_r != 8'sd0);
        neg_b_r <= shoulder_r ? rx_r[7] : (!rx_r[7] && (rx_r != 8'sd0));
        ev_r    <= exit_c ? EV_EXIT : (enter_c ? EV_ENTER : EV_NONE);
        wp_r    <= exit_c;
        wr_r    <= exit_c;
        wl_r    <= exit_c;
      end
      OP_MB1:    qa_r <= prod_r[S_RATE +: Q_W];
      OP_UPDATE: begin
        wp_r <= pan_moves;
        wr_r <= (rtot != 21'sd0);
        wl_r <= (ltot != 21'sd0);
      end
      OP_LR1:    lvl_p_r <= lvl_from_pan;
      OP_LL1:    lvl_r_r <= lvl_from_right;
      OP_FINISH: lvl_l_r <= lvl_from_left;
      default: begin
      end
    endcase
    if (cmd.op == OP_PUSH && out_free) begin
      out_user_r <= ev_r;
      out_data_r <= {2'd0,
                     wl_r ? lvl_l_r : 14'd0,
                     wr_r ? lvl_r_r : 14'd0,
                     wp_r ? lvl_p_r : 14'd0,
                     wl_r, wr_r, wp_r,
                     left_r, right_r, pan_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // clamping keeps every axis inside its travel
  a_pan_range: assert property (@(posedge clk) disable iff (!rst_n)
    pan_r >= PAN_MIN && pan_r <= PAN_MAX)
    else $error("pan position out of range");

  a_pivot_range: assert property (@(posedge clk) disable iff (!rst_n)
    right_r >= RIGHT_MIN && right_r <= RIGHT_MAX && left_r >= LEFT_MIN && left_r <= LEFT_MAX)
    else $error("pivot position out of range");

  // an unwritten pan axis reports no pan level
  a_level_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[33] |-> out_tdata[49:36] == 14'd0)
    else $error("pan level set without a pan write");

  // enter leaves the block active, exit leaves it inactive with every axis written
  a_mode_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_DECIDE && enter_c |=> active_r)
    else $error("enter event without manual mode");

  a_exit_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_DECIDE && exit_c |=> !active_r && wp_r && wr_r && wl_r)
    else $error("exit event did not release all axes");

endmodule

`default_nettype wire

### sv/joystick_rate_servo_integrator_unit.sv
// joystick_rate_servo_integrator_unit: top level joining config, sequencer and datapath
// depends on jrsi_pkg, jrsi_cfg, jrsi_ctrl, jrsi_dp
//
// Turns joystick rate ticks into pan and pivot servo targets. One item is taken at a time:
// a tick that integrates runs the decide, rate multiply, update, level, finish and push
// steps before the block is ready again, other items skip rate multiply and update; push
// stalls while the result register is occupied. One shared 30x31 multiplier runs three
// passes for each of the two rate deltas and two passes for each of the three levels.
// A finished result sits in the output register, so the next item can be accepted while it
// waits. Configuration writes are taken on any cycle and should only be made while idle.
`default_nettype none

module joystick_rate_servo_integrator_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // tdata, lowest bit up: playback_mode, now_ms[31:0], last_recv_ms[31:0],
  // rate_x[7:0], rate_y[7:0], shoulder_held, zero fill
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [87:0] in_tdata,
  input  wire logic [0:0]  in_tuser,   // action
  // tdata, lowest bit up: pan_pwm[10:0], right_pwm[10:0], left_pwm[10:0], pan_written,
  // right_written, left_written, pan_level[13:0], right_level[13:0], left_level[13:0], zero fill
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,
  output logic [1:0]       out_tuser,  // mode_event
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import jrsi_pkg::*;

  cfg_regs_t regs;
  dp_cmd_t   cmd;
  dp_sts_t   sts;

  jrsi_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  jrsi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  jrsi_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg        (regs),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire
